/* sv/gfes_pkg.sv */
// Shared types, constants and helpers for the grid field energy sum block.
// Used by the interfaces, the register file, the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package gfes_pkg;

  localparam int MAX_GRID_DEF   = 64;
  localparam int FIELD_BITS_DEF = 16;

  localparam int FIELD_W   = 16;
  localparam int COEF_W    = 12;
  localparam int ENERGY_W  = 63;
  localparam int SIZE_W    = 7;
  localparam int WT_W      = 3;
  localparam int NUM_TERMS = 6;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Register indexes (word address paddr[3:2])
  localparam logic [1:0] REG_GRID_X = 2'd0;
  localparam logic [1:0] REG_GRID_Y = 2'd1;
  localparam logic [1:0] REG_GRID_Z = 2'd2;

  // Term order inside the six-wide arrays
  localparam int TERM_EX = 0;
  localparam int TERM_EY = 1;
  localparam int TERM_EZ = 2;
  localparam int TERM_BX = 3;
  localparam int TERM_BY = 4;
  localparam int TERM_BZ = 5;

  typedef struct packed {
    logic signed [FIELD_W-1:0] e_x;
    logic signed [FIELD_W-1:0] e_y;
    logic signed [FIELD_W-1:0] e_z;
    logic signed [FIELD_W-1:0] b_x;
    logic signed [FIELD_W-1:0] b_y;
    logic signed [FIELD_W-1:0] b_z;
    logic [COEF_W-1:0]         perm_x;
    logic [COEF_W-1:0]         perm_y;
    logic [COEF_W-1:0]         perm_z;
    logic [COEF_W-1:0]         inv_mu_x;
    logic [COEF_W-1:0]         inv_mu_y;
    logic [COEF_W-1:0]         inv_mu_z;
  } in_item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy_ex;
    logic [ENERGY_W-1:0] energy_ey;
    logic [ENERGY_W-1:0] energy_ez;
    logic [ENERGY_W-1:0] energy_bx;
    logic [ENERGY_W-1:0] energy_by;
    logic [ENERGY_W-1:0] energy_bz;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } cfg_t;

  // Controller to datapath: pipeline advance, accumulate strobes, term weights
  typedef struct packed {
    logic                             adv;
    logic                             acc_en;
    logic                             acc_last;
    logic [NUM_TERMS-1:0][WT_W-1:0]   wt;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/gfes_if.sv */
// Valid/ready channel interfaces for voxel items in and energy items out.
// Depends on gfes_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface gfes_in_if import gfes_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gfes_out_if import gfes_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/gfes_cfg.sv */
// APB register file holding the three grid size registers.
// Depends on gfes_pkg for register indexes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module gfes_cfg import gfes_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [SIZE_W-1:0] size_x_q, size_x_d;
  logic [SIZE_W-1:0] size_y_q, size_y_d;
  logic [SIZE_W-1:0] size_z_q, size_z_d;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    size_x_d = size_x_q;
    size_y_d = size_y_q;
    size_z_d = size_z_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_GRID_X: size_x_d = pwdata[SIZE_W-1:0];
        REG_GRID_Y: size_y_d = pwdata[SIZE_W-1:0];
        REG_GRID_Z: size_z_d = pwdata[SIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_X: prdata = APB_DW'(size_x_q);
      REG_GRID_Y: prdata = APB_DW'(size_y_q);
      REG_GRID_Z: prdata = APB_DW'(size_z_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
      size_z_q <= SIZE_RESET;
    end else begin
      size_x_q <= size_x_d;
      size_y_q <= size_y_d;
      size_z_q <= size_z_d;
    end
  end

  assign cfg_o.size_x = size_x_q;
  assign cfg_o.size_y = size_y_q;
  assign cfg_o.size_z = size_z_q;

endmodule

`default_nettype wire

/* sv/gfes_ctrl.sv */
// Controller: raster position counters, stencil weights, frame end detect,
// pipeline valid tracking and output handshake. Depends on gfes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfes_ctrl import gfes_pkg::*; #(
  parameter int MAX_GRID = MAX_GRID_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o
);

  localparam logic [SIZE_W-1:0] MAX_N = SIZE_W'(MAX_GRID);

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
    logic [SIZE_W-1:0] n;
    n = r;
    if (r == '0) n = SIZE_W'(1);
    else if (r > MAX_N) n = MAX_N;
    return n;
  endfunction

  function automatic logic in_range(input logic [SIZE_W-1:0] p,
                                    input logic [SIZE_W-1:0] n);
    return (p != '0) && (p <= n);
  endfunction

  // Number of interior cells touching the edge or face at p: 0, 1 or 2
  function automatic logic [1:0] pair_cnt(input logic [SIZE_W-1:0] p,
                                          input logic [SIZE_W-1:0] n);
    logic lo;
    lo = (p >= SIZE_W'(2)) && (p <= n + SIZE_W'(1));
    return {1'b0, in_range(p, n)} + {1'b0, lo};
  endfunction

  logic [SIZE_W-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, pos_z_q, pos_z_d;
  logic              v1_q, v1_d, v2_q, v2_d;
  logic              last1_q, last1_d, last2_q, last2_d;
  logic              out_valid_q, out_valid_d;

  logic [SIZE_W-1:0] n_x, n_y, n_z;
  logic              end_x, end_y, end_z, last;
  logic              ix, iy, iz;
  logic [1:0]        cx, cy, cz;
  logic              adv, take, acc_last;

  assign n_x = eff_size(cfg_i.size_x);
  assign n_y = eff_size(cfg_i.size_y);
  assign n_z = eff_size(cfg_i.size_z);

  assign ix = in_range(pos_x_q, n_x);
  assign iy = in_range(pos_y_q, n_y);
  assign iz = in_range(pos_z_q, n_z);
  assign cx = pair_cnt(pos_x_q, n_x);
  assign cy = pair_cnt(pos_y_q, n_y);
  assign cz = pair_cnt(pos_z_q, n_z);

  assign end_x = pos_x_q >= n_x + SIZE_W'(1);
  assign end_y = pos_y_q >= n_y + SIZE_W'(1);
  assign end_z = pos_z_q >= n_z + SIZE_W'(1);
  assign last  = end_x && end_y && end_z;

  // Hold the pipe only when a frame result would land on an untaken one
  assign adv      = !(out_valid_q && !out_ready_i && v2_q && last2_q);
  assign take     = in_valid_i && adv;
  assign acc_last = adv && v2_q && last2_q;

  always_comb begin
    cmd_o.adv      = adv;
    cmd_o.acc_en   = adv && v2_q;
    cmd_o.acc_last = acc_last;
    cmd_o.wt[TERM_EX] = ix ? WT_W'(3'(cy) * 3'(cz)) : '0;
    cmd_o.wt[TERM_EY] = iy ? WT_W'(3'(cx) * 3'(cz)) : '0;
    cmd_o.wt[TERM_EZ] = iz ? WT_W'(3'(cx) * 3'(cy)) : '0;
    cmd_o.wt[TERM_BX] = (iy && iz) ? {cx, 1'b0} : '0;
    cmd_o.wt[TERM_BY] = (ix && iz) ? {cy, 1'b0} : '0;
    cmd_o.wt[TERM_BZ] = (ix && iy) ? {cz, 1'b0} : '0;
  end

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (take) begin
      if (last) begin
        pos_x_d = SIZE_W'(1);
        pos_y_d = SIZE_W'(1);
        pos_z_d = SIZE_W'(1);
      end else if (end_x) begin
        pos_x_d = SIZE_W'(1);
        if (end_y) begin
          pos_y_d = SIZE_W'(1);
          pos_z_d = pos_z_q + SIZE_W'(1);
        end else begin
          pos_y_d = pos_y_q + SIZE_W'(1);
        end
      end else begin
        pos_x_d = pos_x_q + SIZE_W'(1);
      end
    end
  end

  always_comb begin
    v1_d    = v1_q;
    v2_d    = v2_q;
    last1_d = last1_q;
    last2_d = last2_q;
    if (adv) begin
      v1_d    = take;
      last1_d = take && last;
      v2_d    = v1_q;
      last2_d = last1_q;
    end
    out_valid_d = out_valid_q;
    if (acc_last) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= SIZE_W'(1);
      pos_y_q     <= SIZE_W'(1);
      pos_z_q     <= SIZE_W'(1);
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      last1_q     <= 1'b0;
      last2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      pos_z_q     <= pos_z_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      last1_q     <= last1_d;
      last2_q     <= last2_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = adv;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* sv/gfes_dp.sv */
// Datapath: square stage, coefficient multiply stage, weighted saturating
// accumulators and the result register. Depends on gfes_pkg for cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module gfes_dp import gfes_pkg::*; #(
  parameter int FIELD_BITS = FIELD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  in_item_t  item_i,
  input  cmd_t      cmd_i,
  output out_item_t result_o
);

  localparam int SQ_W   = 2 * FIELD_BITS;
  localparam int PROD_W = SQ_W + COEF_W;
  localparam int TERM_W = PROD_W + 2;

  logic [NUM_TERMS-1:0][FIELD_W-1:0]  fld;
  logic [NUM_TERMS-1:0][COEF_W-1:0]   coef;
  logic [NUM_TERMS-1:0][FIELD_BITS-1:0] mag;

  logic [NUM_TERMS-1:0][SQ_W-1:0]     sq1_q;
  logic [NUM_TERMS-1:0][COEF_W-1:0]   coef1_q;
  logic [NUM_TERMS-1:0][WT_W-1:0]     wt1_q;
  logic [NUM_TERMS-1:0][PROD_W-1:0]   prod2_q;
  logic [NUM_TERMS-1:0][WT_W-1:0]     wt2_q;

  logic [NUM_TERMS-1:0][TERM_W-1:0]   term;
  logic [NUM_TERMS-1:0][ENERGY_W:0]   sum;
  logic [NUM_TERMS-1:0][ENERGY_W-1:0] sat;
  logic [NUM_TERMS-1:0][ENERGY_W-1:0] acc_q, acc_d;
  logic [NUM_TERMS-1:0][ENERGY_W-1:0] res_q;

  always_comb begin
    fld[TERM_EX]  = item_i.e_x;
    fld[TERM_EY]  = item_i.e_y;
    fld[TERM_EZ]  = item_i.e_z;
    fld[TERM_BX]  = item_i.b_x;
    fld[TERM_BY]  = item_i.b_y;
    fld[TERM_BZ]  = item_i.b_z;
    coef[TERM_EX] = item_i.perm_x;
    coef[TERM_EY] = item_i.perm_y;
    coef[TERM_EZ] = item_i.perm_z;
    coef[TERM_BX] = item_i.inv_mu_x;
    coef[TERM_BY] = item_i.inv_mu_y;
    coef[TERM_BZ] = item_i.inv_mu_z;
    // Magnitude of the low FIELD_BITS bits as two's complement
    for (int k = 0; k < NUM_TERMS; k++) begin
      mag[k] = fld[k][FIELD_BITS-1] ? (~fld[k][FIELD_BITS-1:0] + FIELD_BITS'(1))
                                    : fld[k][FIELD_BITS-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      case (wt2_q[k])
        3'd1:    term[k] = TERM_W'(prod2_q[k]);
        3'd2:    term[k] = {1'b0, prod2_q[k], 1'b0};
        3'd4:    term[k] = {prod2_q[k], 2'b00};
        default: term[k] = '0;
      endcase
      sum[k] = {1'b0, acc_q[k]} + (ENERGY_W + 1)'(term[k]);
      // Clamp at the top of the range
      sat[k] = sum[k][ENERGY_W] ? '1 : sum[k][ENERGY_W-1:0];
      acc_d[k] = acc_q[k];
      if (cmd_i.acc_en) acc_d[k] = cmd_i.acc_last ? '0 : sat[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.adv) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        sq1_q[k]   <= SQ_W'(mag[k]) * SQ_W'(mag[k]);
        coef1_q[k] <= coef[k];
        prod2_q[k] <= PROD_W'(sq1_q[k]) * PROD_W'(coef1_q[k]);
      end
      wt1_q <= cmd_i.wt;
      wt2_q <= wt1_q;
    end
    if (cmd_i.acc_last) res_q <= sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign result_o.energy_ex = res_q[TERM_EX];
  assign result_o.energy_ey = res_q[TERM_EY];
  assign result_o.energy_ez = res_q[TERM_EZ];
  assign result_o.energy_bx = res_q[TERM_BX];
  assign result_o.energy_by = res_q[TERM_BY];
  assign result_o.energy_bz = res_q[TERM_BZ];

endmodule

`default_nettype wire

/* sv/grid_field_energy_sum_core.sv */
// Grid field energy sum: top level joining the register file, the controller
// and the datapath. Depends on gfes_pkg and the interfaces in gfes_if.
//
// Usage:
//   items_i takes one voxel per item (six field components and six material
//   coefficients) in x-fastest raster order over positions 1..n+1 on each
//   axis, ghost layer included. energy_o gives one item with the six energy
//   sums, in quarter units and saturating, after the frame's last voxel.
//   Grid sizes are written over the APB port; write them while no voxel is
//   in flight.
//   Throughput: one voxel per cycle while the pipe is not held (see Stalls).
//   Pipeline: a result is valid once its last voxel has passed the square
//   stage, which loads at the accepting edge, then the coefficient multiply
//   stage and then the accumulate stage with the result register.
//   Stalls: while a result waits on energy_o, voxels keep flowing; the pipe
//   holds (and items_i.ready drops) only when the next frame's last voxel
//   reaches the accumulators before the waiting result is taken.
//   Reset: sizes return to 64, the position to (1,1,1), the sums to zero and
//   the pipe empties.
`timescale 1ns / 1ps
`default_nettype none

module grid_field_energy_sum_core import gfes_pkg::*; #(
  parameter int MAX_GRID   = MAX_GRID_DEF,
  parameter int FIELD_BITS = FIELD_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  gfes_in_if.sink                items_i,
  gfes_out_if.source             energy_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t      cfg;
  cmd_t      cmd;
  logic      in_ready;
  logic      out_valid;
  out_item_t result;

  gfes_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gfes_ctrl #(
    .MAX_GRID (MAX_GRID)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (items_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (energy_o.ready),
    .cmd_o       (cmd)
  );

  gfes_dp #(
    .FIELD_BITS (FIELD_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (items_i.data),
    .cmd_i    (cmd),
    .result_o (result)
  );

  assign items_i.ready  = in_ready;
  assign energy_o.valid = out_valid;
  assign energy_o.data  = result;

endmodule

`default_nettype wire

/* dv/gfes_energy_checker.sv */
// Scoreboard for the grid field energy sum core: tracks grid sizes from APB writes,
// predicts the six energy sums per frame and compares each energy item.
// Depends on gfes_pkg and the channel interfaces in gfes_if.
`timescale 1ns / 1ps

module gfes_energy_checker import gfes_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  gfes_in_if                voxel_mon,
  gfes_out_if               energy_mon,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output int                mismatch_count_o,
  output int                results_due_o,
  output int                frames_checked_o
);

  localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [SIZE_W-1:0] at_x, at_y, at_z;
  logic [63:0]       energy_run [NUM_TERMS];
  out_item_t         energy_due [$];
  int                mismatches = 0;
  int                frames_checked = 0;
  int                due_count = 0;
  string             term_name [NUM_TERMS] =
    '{"energy_ex", "energy_ey", "energy_ez", "energy_bx", "energy_by", "energy_bz"};

  assign mismatch_count_o = mismatches;
  assign results_due_o    = due_count;
  assign frames_checked_o = frames_checked;

  function automatic int eff_size(logic [SIZE_W-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > MAX_GRID_DEF) return MAX_GRID_DEF;
    return int'(r);
  endfunction

  function automatic int in_grid(int p, int n);
    return (p >= 1 && p <= n) ? 1 : 0;
  endfunction

  // interior voxels on this axis whose stencil reaches position p
  function automatic int span(int p, int n);
    return in_grid(p, n) + in_grid(p - 1, n);
  endfunction

  function automatic logic [31:0] field_sq(logic [FIELD_W-1:0] f);
    logic [16:0] mag;
    mag = f[FIELD_W-1] ? (17'h10000 - {1'b0, f}) : {1'b0, f};
    return 32'(mag) * 32'(mag);
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] acc, int w, logic [COEF_W-1:0] c,
                                          logic [FIELD_W-1:0] f);
    logic [63:0] s;
    s = acc + 64'(w) * 64'(c) * 64'(field_sq(f));
    return (s > SAT_MAX) ? SAT_MAX : s;
  endfunction

  task automatic absorb_voxel(input in_item_t v);
    int                nx, ny, nz, ix, iy, iz, cx, cy, cz;
    int                wt [NUM_TERMS];
    logic [FIELD_W-1:0] comp [NUM_TERMS];
    logic [COEF_W-1:0]  coef [NUM_TERMS];
    out_item_t         due;
    nx = eff_size(size_x);
    ny = eff_size(size_y);
    nz = eff_size(size_z);
    ix = in_grid(int'(at_x), nx);
    iy = in_grid(int'(at_y), ny);
    iz = in_grid(int'(at_z), nz);
    cx = span(int'(at_x), nx);
    cy = span(int'(at_y), ny);
    cz = span(int'(at_z), nz);
    wt[TERM_EX] = ix * cy * cz;
    wt[TERM_EY] = cx * iy * cz;
    wt[TERM_EZ] = cx * cy * iz;
    wt[TERM_BX] = 2 * cx * iy * iz;
    wt[TERM_BY] = 2 * ix * cy * iz;
    wt[TERM_BZ] = 2 * ix * iy * cz;
    comp = '{v.e_x, v.e_y, v.e_z, v.b_x, v.b_y, v.b_z};
    coef = '{v.perm_x, v.perm_y, v.perm_z, v.inv_mu_x, v.inv_mu_y, v.inv_mu_z};
    for (int k = 0; k < NUM_TERMS; k++)
      energy_run[k] = sat_add(energy_run[k], wt[k], coef[k], comp[k]);

    if (int'(at_x) >= nx + 1 && int'(at_y) >= ny + 1 && int'(at_z) >= nz + 1) begin
      due.energy_ex = energy_run[TERM_EX][ENERGY_W-1:0];
      due.energy_ey = energy_run[TERM_EY][ENERGY_W-1:0];
      due.energy_ez = energy_run[TERM_EZ][ENERGY_W-1:0];
      due.energy_bx = energy_run[TERM_BX][ENERGY_W-1:0];
      due.energy_by = energy_run[TERM_BY][ENERGY_W-1:0];
      due.energy_bz = energy_run[TERM_BZ][ENERGY_W-1:0];
      energy_due.push_back(due);
      for (int k = 0; k < NUM_TERMS; k++) energy_run[k] = '0;
      at_x = 1;
      at_y = 1;
      at_z = 1;
    end else if (int'(at_x) >= nx + 1) begin
      // positions past the edge wrap as if they sat on it
      at_x = 1;
      if (int'(at_y) >= ny + 1) begin
        at_y = 1;
        at_z = at_z + 1'b1;
      end else begin
        at_y = at_y + 1'b1;
      end
    end else begin
      at_x = at_x + 1'b1;
    end
  endtask

  task automatic check_energy(input out_item_t got);
    out_item_t           want;
    logic [ENERGY_W-1:0] want_f [NUM_TERMS];
    logic [ENERGY_W-1:0] got_f [NUM_TERMS];
    if (energy_due.size() == 0) begin
      $display("%0t: energy item with none expected, expected none actual ex=%0d bz=%0d",
               $time, got.energy_ex, got.energy_bz);
      mismatches++;
      return;
    end
    want = energy_due.pop_front();
    frames_checked++;
    want_f = '{want.energy_ex, want.energy_ey, want.energy_ez,
               want.energy_bx, want.energy_by, want.energy_bz};
    got_f  = '{got.energy_ex, got.energy_ey, got.energy_ez,
               got.energy_bx, got.energy_by, got.energy_bz};
    for (int k = 0; k < NUM_TERMS; k++) begin
      if (want_f[k] !== got_f[k]) begin
        $display("%0t: %s expected %0d actual %0d", $time, term_name[k], want_f[k], got_f[k]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x = SIZE_RESET;
      size_y = SIZE_RESET;
      size_z = SIZE_RESET;
      at_x   = 1;
      at_y   = 1;
      at_z   = 1;
      for (int k = 0; k < NUM_TERMS; k++) energy_run[k] = '0;
      energy_due.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[APB_AW-1:2])
          REG_GRID_X: size_x = pwdata_i[SIZE_W-1:0];
          REG_GRID_Y: size_y = pwdata_i[SIZE_W-1:0];
          REG_GRID_Z: size_z = pwdata_i[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (energy_mon.valid && energy_mon.ready) check_energy(energy_mon.data);
      if (voxel_mon.valid && voxel_mon.ready) absorb_voxel(voxel_mon.data);
    end
    due_count = energy_due.size();
  end

endmodule

/* dv/tb_grid_field_energy_sum_core.sv */
// Testbench top for the grid field energy sum core: clock, reset, APB grid setup,
// voxel stimulus and result back-pressure. Checking lives in gfes_energy_checker.
// Depends on gfes_pkg, gfes_if and the core RTL.
`timescale 1ns / 1ps

module tb_grid_field_energy_sum_core;
  import gfes_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 10;
  localparam int TAIL_LIMIT     = 1000;
  localparam int TARGET_VOXELS  = 1500;
  localparam int CALM_AFTER     = 1250;

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  gfes_in_if  voxel_ch ();
  gfes_out_if energy_ch ();

  int mismatches, results_due, frames_checked;
  int voxels_sent = 0;
  int settings = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  logic [SIZE_W-1:0] reg_x = SIZE_RESET, reg_y = SIZE_RESET, reg_z = SIZE_RESET;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  grid_field_energy_sum_core u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .items_i  (voxel_ch),
    .energy_o (energy_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  gfes_energy_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .voxel_mon        (voxel_ch),
    .energy_mon       (energy_ch),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatches),
    .results_due_o    (results_due),
    .frames_checked_o (frames_checked)
  );

  always @(posedge clk) begin
    if (!rst_n || psel || (voxel_ch.valid && voxel_ch.ready) ||
        (energy_ch.valid && energy_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // back-pressure on the energy channel, off in the calm tail
  initial begin
    energy_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (calm || $urandom_range(2) != 0) begin
        energy_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        energy_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  function automatic int clamp_grid(logic [SIZE_W-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > MAX_GRID_DEF) return MAX_GRID_DEF;
    return int'(r);
  endfunction

  function automatic logic [FIELD_W-1:0] rand_field();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return '1;
      4: return FIELD_W'($urandom_range(0, 15));
      default: return FIELD_W'($urandom());
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  function automatic in_item_t rand_voxel();
    in_item_t v;
    v.e_x      = rand_field();
    v.e_y      = rand_field();
    v.e_z      = rand_field();
    v.b_x      = rand_field();
    v.b_y      = rand_field();
    v.b_z      = rand_field();
    v.perm_x   = rand_coef();
    v.perm_y   = rand_coef();
    v.perm_z   = rand_coef();
    v.inv_mu_x = rand_coef();
    v.inv_mu_y = rand_coef();
    v.inv_mu_z = rand_coef();
    return v;
  endfunction

  // field and coefficient extremes, one pattern per voxel of a 1x1x1 frame
  function automatic in_item_t corner_voxel(int i);
    logic [FIELD_W-1:0] f;
    logic [COEF_W-1:0]  c;
    case (i)
      0: begin f = 16'h8000; c = '1; end
      1: begin f = 16'h7FFF; c = '1; end
      2: begin f = '0; c = '1; end
      3: begin f = '1; c = '0; end
      4: begin f = 16'h8000; c = '0; end
      5: begin f = 16'h0001; c = 12'h001; end
      6: begin f = 16'h5555; c = 12'hAAA; end
      default: begin f = 16'hAAAA; c = 12'h555; end
    endcase
    return {{6{f}}, {6{c}}};
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(9))
      0: return '0;
      1: return SIZE_W'($urandom_range(4, 5));
      default: return SIZE_W'($urandom_range(1, 3));
    endcase
  endfunction

  task automatic push_voxel(input in_item_t v);
    if (!calm && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      voxel_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    voxel_ch.valid <= 1'b1;
    voxel_ch.data  <= v;
    @(posedge clk);
    while (!voxel_ch.ready) @(posedge clk);
    voxels_sent++;
  endtask

  // hold the voxel stream until every energy item is out and the pipe is empty
  task automatic settle();
    voxel_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [SIZE_W-1:0] val);
    logic [APB_DW-1:0] word;
    word = $urandom();
    word[SIZE_W-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_grid(input logic [SIZE_W-1:0] x, input logic [SIZE_W-1:0] y,
                          input logic [SIZE_W-1:0] z);
    settle();
    apb_write(REG_GRID_X, x);
    apb_write(REG_GRID_Y, y);
    apb_write(REG_GRID_Z, z);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_x = x;
    reg_y = y;
    reg_z = z;
    settings++;
  endtask

  task automatic send_frames(input int count);
    int len;
    len = (clamp_grid(reg_x) + 1) * (clamp_grid(reg_y) + 1) * (clamp_grid(reg_z) + 1);
    repeat (count * len) push_voxel(rand_voxel());
  endtask

  initial begin : stimulus
    int phase;
    int waited;
    voxel_ch.valid <= 1'b0;
    voxel_ch.data  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // smallest grid with every corner pattern
    set_grid(1, 1, 1);
    for (int i = 0; i < 8; i++) push_voxel(corner_voxel(i));

    // shrink mid-frame: x lands past the new edge, the frame closes three voxels later
    set_grid(2, 2, 2);
    repeat (14) push_voxel(rand_voxel());
    set_grid(1, 2, 1);
    repeat (3) push_voxel(rand_voxel());

    phase = 0;
    while (voxels_sent < TARGET_VOXELS && phase < 400) begin
      case (phase)
        0: set_grid(127, 0, 0);
        1: set_grid(1, 1, 64);
        default: set_grid(pick_size(), pick_size(), pick_size());
      endcase
      idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
      if (voxels_sent >= CALM_AFTER) calm = 1'b1;
      send_frames(phase < 2 ? 1 : $urandom_range(1, 3));
      phase++;
    end

    voxel_ch.valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (results_due != 0 && waited < TAIL_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due != 0)
      $display("%0t: %0d energy item(s) never arrived", $time, results_due);
    $display("Run: %0d voxels, %0d energy items compared, %0d grid settings", voxels_sent,
             frames_checked, settings);
    $display("Run: corner field values, zero and oversize grid registers, mid-frame shrink");
    if (mismatches == 0 && results_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/gfes_pkg.sv
sv/gfes_if.sv
sv/gfes_cfg.sv
sv/gfes_ctrl.sv
sv/gfes_dp.sv
sv/grid_field_energy_sum_core.sv
dv/gfes_energy_checker.sv
dv/tb_grid_field_energy_sum_core.sv
